FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertions with a reset disable, shared by all checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `ASSERT_CLK(lbl, clk, rstn, !(cond), msg)

`endif

FILE: sv/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// shared types and constants of the binary to decimal ascii converter
// ----------------------------------------------------------------------------
package b2da_pkg;

    localparam int B2DA_MAX_DIGITS = 20;
    localparam int NUM_W           = 64;
    localparam int CMD_W           = 3;
    localparam int CHAR_W          = 6;
    localparam int ITER_W          = 4;   // count of 4-bit conversion steps, minus one
    localparam int NDIG_W          = 3;   // fixed digit count, minus one
    localparam int DAB_STEPS       = 4;   // bits consumed per conversion cycle
    localparam int QUEUE_DEPTH     = 2;
    localparam int QA_W            = $clog2(QUEUE_DEPTH);
    localparam int QC_W            = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

    typedef enum logic [CMD_W-1:0] {
        CMD_DEC_VAR = 3'd0,
        CMD_DEC5    = 3'd1,
        CMD_DEC4    = 3'd2,
        CMD_DEC3    = 3'd3,
        CMD_BIN8    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_VAR,
        KIND_FIX,
        KIND_BIN
    } t_kind;

    // one classified job, value left aligned so conversion starts at bit 63
    typedef struct packed {
        t_kind              kind;
        logic [NDIG_W-1:0]  ndig_m1;
        logic [ITER_W-1:0]  iters_m1;
        logic [NUM_W-1:0]   bits;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_back_state;

endpackage

FILE: sv/b2da_ifs.sv
// ----------------------------------------------------------------------------
// b2da channel interfaces
// valid/ready channels for numbers in and characters out
// ----------------------------------------------------------------------------
interface b2da_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [63:0] number;

    modport source (output valid, output command, output number, input ready);
    modport sink (input valid, input command, input number, output ready);
endinterface

interface b2da_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);
endinterface

FILE: sv/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// converts a command and a 64-bit number into a burst of ascii digit characters
// ----------------------------------------------------------------------------
// each input transaction carries a command and a number; the block answers
// with ascii digits, most significant first, last set on the final one.
// command 0 gives the whole 64-bit value in decimal with no leading zeros
// (a lone '0' for zero), commands 1 to 3 give exactly 5, 4 or 3 decimal
// digits of the low 32, 16 or 8 bits, command 4 gives the low byte as eight
// binary digits, and commands 5 to 7 are taken and produce nothing.
// flow: the front registers each number and passes it on through a
// two-entry job queue, so up to three numbers can be held while one converts.
// the back converts with a double-dabble unit that eats four bits a cycle;
// command 4 skips conversion. it then sends one character a cycle while the
// output is ready, and in command 0 also steps over each suppressed leading
// zero without sending it. the output register holds each character while
// the receiver stalls; the next one is built as the current one is taken.
module binary_to_decimal_ascii
    import b2da_pkg::*;
#(
    parameter int MAX_DIGITS = B2DA_MAX_DIGITS
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    b2da_in_if.sink    i_in,
    b2da_out_if.source o_out
);

    // front to queue
    logic f_valid;
    logic f_ready;
    t_job f_job;

    // queue to back
    logic q_valid;
    logic q_ready;
    t_job q_job;

    // classify and align the incoming number
    b2da_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (f_valid),
        .i_push_ready (f_ready),
        .o_push_job   (f_job)
    );

    // decouples acceptance from conversion
    b2da_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_job   (f_job),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_job    (q_job)
    );

    // conversion and character output
    b2da_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (q_valid),
        .o_pop_ready (q_ready),
        .i_pop_job   (q_job),
        .o_out       (o_out)
    );

endmodule

FILE: sv/b2da_front.sv
// ----------------------------------------------------------------------------
// b2da_front
// accepts numbers, drops unknown commands, aligns the value for conversion
// ----------------------------------------------------------------------------
module b2da_front
    import b2da_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    b2da_in_if.sink       i_in,
    output logic          o_push_valid,
    input  logic          i_push_ready,
    output t_job          o_push_job
);

    logic r_valid;
    t_job r_job;
    t_job n_job;
    logic n_keep;

    assign i_in.ready   = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_job   = r_job;

    always_comb begin
        n_job  = '0;
        n_keep = 1'b1;
        unique case (i_in.command)
            CMD_DEC_VAR: begin
                n_job.kind     = KIND_VAR;
                n_job.iters_m1 = 4'd15;
                n_job.bits     = i_in.number;
            end
            CMD_DEC5: begin
                n_job.kind     = KIND_FIX;
                n_job.ndig_m1  = 3'd4;
                n_job.iters_m1 = 4'd7;
                n_job.bits     = {i_in.number[31:0], 32'd0};
            end
            CMD_DEC4: begin
                n_job.kind     = KIND_FIX;
                n_job.ndig_m1  = 3'd3;
                n_job.iters_m1 = 4'd3;
                n_job.bits     = {i_in.number[15:0], 48'd0};
            end
            CMD_DEC3: begin
                n_job.kind     = KIND_FIX;
                n_job.ndig_m1  = 3'd2;
                n_job.iters_m1 = 4'd1;
                n_job.bits     = {i_in.number[7:0], 56'd0};
            end
            CMD_BIN8: begin
                n_job.kind     = KIND_BIN;
                n_job.ndig_m1  = 3'd7;
                n_job.bits     = {i_in.number[7:0], 56'd0};
            end
            default: begin
                n_keep = 1'b0;   // unused command, no output
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= n_keep;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_job <= n_job;
        end
    end

endmodule

FILE: sv/b2da_queue.sv
// ----------------------------------------------------------------------------
// b2da_queue
// small show-ahead job queue between front and back
// ----------------------------------------------------------------------------
module b2da_queue
    import b2da_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_job  i_push_job,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_job  o_pop_job
);

    t_job            r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0] r_wr;
    logic [QA_W-1:0] r_rd;
    logic [QC_W-1:0] r_cnt;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_cnt != QC_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_job    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    function automatic logic [QA_W-1:0] next_ptr(input logic [QA_W-1:0] p);
        next_ptr = (p == QA_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= next_ptr(r_wr);
            end
            if (pop) begin
                r_rd <= next_ptr(r_rd);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

endmodule

FILE: sv/b2da_back.sv
// ----------------------------------------------------------------------------
// b2da_back
// double-dabble conversion, four bits a cycle, then one character a cycle while the output is ready
// ----------------------------------------------------------------------------
module b2da_back
    import b2da_pkg::*;
#(
    parameter int MAX_DIGITS = B2DA_MAX_DIGITS
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_pop_valid,
    output logic      o_pop_ready,
    input  t_job      i_pop_job,
    b2da_out_if.source o_out
);

    localparam int BCD_W = MAX_DIGITS * 4;
    localparam int IDX_W = $clog2(MAX_DIGITS);

    t_back_state       r_state;
    t_back_state       n_state;
    logic [NUM_W-1:0]  r_bin;
    logic [NUM_W-1:0]  n_bin;
    logic [BCD_W-1:0]  r_bcd;
    logic [BCD_W-1:0]  n_bcd;
    logic [ITER_W-1:0] r_iter;
    logic [ITER_W-1:0] n_iter;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic              r_seen;
    logic              n_seen;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [CHAR_W-1:0] r_char;
    logic [CHAR_W-1:0] n_char;
    logic              r_last;
    logic              n_last;

    logic [BCD_W-1:0]  dab_bcd;
    logic [NUM_W-1:0]  dab_bin;
    logic [BCD_W-1:0]  bin_bcd;
    logic [3:0]        digit;
    logic              slot_free;

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_char;
    assign o_out.last      = r_last;
    assign o_pop_ready     = (r_state == ST_IDLE);
    assign digit           = r_bcd[{r_idx, 2'b00} +: 4];
    assign slot_free       = !r_out_valid || o_out.ready;

    // four shift-and-adjust steps
    always_comb begin
        dab_bcd = r_bcd;
        dab_bin = r_bin;
        for (int s = 0; s < DAB_STEPS; s++) begin
            for (int d = 0; d < MAX_DIGITS; d++) begin
                if (dab_bcd[4*d +: 4] >= 4'd5) begin
                    dab_bcd[4*d +: 4] = dab_bcd[4*d +: 4] + 4'd3;
                end
            end
            dab_bcd = {dab_bcd[BCD_W-2:0], dab_bin[NUM_W-1]};
            dab_bin = {dab_bin[NUM_W-2:0], 1'b0};
        end
    end

    // binary mode: each bit of the byte becomes one digit
    always_comb begin
        bin_bcd = '0;
        for (int k = 0; k < 8; k++) begin
            bin_bcd[4*k] = i_pop_job.bits[NUM_W-8+k];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_iter      = r_iter;
        n_idx       = r_idx;
        n_seen      = r_seen;
        n_out_valid = r_out_valid && !o_out.ready;
        n_char      = r_char;
        n_last      = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (i_pop_valid) begin
                    n_bin  = i_pop_job.bits;
                    n_iter = i_pop_job.iters_m1;
                    n_idx  = IDX_W'(i_pop_job.ndig_m1);
                    n_seen = 1'b1;
                    unique case (i_pop_job.kind)
                        KIND_BIN: begin
                            n_bcd   = bin_bcd;
                            n_state = ST_EMIT;
                        end
                        KIND_VAR: begin
                            n_bcd   = '0;
                            n_idx   = IDX_W'(MAX_DIGITS - 1);
                            n_seen  = 1'b0;
                            n_state = ST_CONV;
                        end
                        default: begin
                            n_bcd   = '0;
                            n_state = ST_CONV;
                        end
                    endcase
                end
            end
            ST_CONV: begin
                n_bcd  = dab_bcd;
                n_bin  = dab_bin;
                n_iter = r_iter - 1'b1;
                if (r_iter == '0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_seen && digit == 4'd0 && r_idx != '0) begin
                    n_idx = r_idx - 1'b1;   // leading zero
                end else if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = ASCII_ZERO | {2'b00, digit};
                    n_last      = (r_idx == '0);
                    n_seen      = 1'b1;
                    n_idx       = r_idx - 1'b1;
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_iter <= n_iter;
        r_idx  <= n_idx;
        r_seen <= n_seen;
        r_char <= n_char;
        r_last <= n_last;
    end

endmodule

FILE: sv/b2da_checker.sv
// ----------------------------------------------------------------------------
// b2da_checker
// port-level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b2da_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [5:0] i_out_character,
    input logic       i_out_last
);

    // only ascii digits leave the block
    `ASSERT_CLK(a_char_digit, i_clk, i_rst_n, i_out_valid |-> (i_out_character >= 6'd48 && i_out_character <= 6'd57), "character is not an ascii digit")

    // nothing shown right after reset is released
    `ASSERT_CLK(a_quiet_after_reset, i_clk, i_rst_n, $past(!i_rst_n) |-> !i_out_valid, "output valid right after reset")

    // a stalled transaction stays offered
    `ASSERT_CLK(a_valid_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid, "output valid dropped while stalled")

    // a stalled transaction keeps its payload
    `ASSERT_CLK(a_payload_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> ($stable(i_out_character) && $stable(i_out_last)), "output payload changed while stalled")

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_character (o_out.character),
    .i_out_last      (o_out.last)
);

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the binary to decimal ascii converter: a short
// table of hand-picked numbers, then random numbers in bursts, each digit burst
// checked character by character against a typed answer or the digit predictor
// ----------------------------------------------------------------------------
module tb_top;
    import b2da_pkg::*;

    localparam int CLK_HALF       = 6;     // 12 ns period
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_NUMBERS = 196;   // random numbers, unused commands included
    localparam int HOLD_AT        = 60;    // numbers taken before the long output stall
    localparam int HOLD_CYCLES    = 250;   // length of that stall
    localparam int DRAIN_CYCLES   = 100;   // cycles waited after the last owed character
    localparam int QUIET_LIMIT    = 2000;  // cycles with no transaction before giving up

    // command codes the block swallows without answering
    localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam logic [NUM_W-1:0] ALL_ONES = {NUM_W{1'b1}};

    // one expected character of a digit burst
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_digit;

    // one row of the directed table; an empty txt means the predictor decides
    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [NUM_W-1:0] num;
        string            txt;
    } t_dir_row;

    typedef enum {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    logic clk = 1'b0;
    logic rst_n;

    b2da_in_if  in_ch ();
    b2da_out_if out_ch ();

    t_digit digits_due [$];     // characters still owed by the block, oldest first
    string  row_txt;            // typed-in answer of the number on the input, if any
    int     err_count     = 0;
    int     numbers_taken = 0;
    int     burst_left    = 0;

    // directed numbers: extremes of every command, zero, digit count edges
    // and the unused command codes
    t_dir_row dir_tbl [24] = '{
        '{CMD_DEC_VAR, 64'd0,                      "0"},
        '{CMD_DEC_VAR, ALL_ONES,                   "18446744073709551615"},
        '{CMD_DEC_VAR, 64'd1,                      "1"},
        '{CMD_DEC_VAR, 64'd9,                      "9"},
        '{CMD_DEC_VAR, 64'd10,                     "10"},
        '{CMD_DEC_VAR, 64'd10000000000000000000,   "10000000000000000000"},
        '{CMD_DEC_VAR, 64'h8000_0000_0000_0000,    ""},
        '{CMD_DEC_VAR, 64'h5555_AAAA_1234_5678,    ""},
        '{CMD_DEC5,    64'd0,                      "00000"},
        '{CMD_DEC5,    ALL_ONES,                   "67295"},
        '{CMD_DEC5,    64'd99999,                  "99999"},
        '{CMD_DEC5,    64'd100000,                 "00000"},
        '{CMD_DEC4,    64'd0,                      "0000"},
        '{CMD_DEC4,    ALL_ONES,                   "5535"},
        '{CMD_DEC4,    64'd9999,                   "9999"},
        '{CMD_DEC3,    64'd0,                      "000"},
        '{CMD_DEC3,    ALL_ONES,                   "255"},
        '{CMD_DEC3,    64'hFFFF_FFFF_FFFF_FF07,    "007"},
        '{CMD_BIN8,    64'd0,                      "00000000"},
        '{CMD_BIN8,    ALL_ONES,                   "11111111"},
        '{CMD_BIN8,    64'hA5,                     "10100101"},
        '{CMD_RSVD_5,  ALL_ONES,                   ""},
        '{CMD_RSVD_6,  64'd0,                      ""},
        '{CMD_RSVD_7,  64'h1234,                   ""}
    };

    binary_to_decimal_ascii DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // digit predictor: works out the burst one number causes and queues it
    // ------------------------------------------------------------------------
    function automatic void predict_digits(input logic [CMD_W-1:0] cmd,
                                           input logic [NUM_W-1:0] num);
        logic [NUM_W-1:0] v;
        int               ndig;
        logic [3:0]       digs [$];
        t_digit           d;
        ndig = 0;
        case (cmd)
            CMD_DEC_VAR: begin
                // no leading zeros, but zero itself still gives one digit
                v = num;
                do begin
                    digs.push_front(4'(v % 10));
                    v = v / 10;
                end while (v != 0);
            end
            CMD_DEC5: begin
                v = num[31:0] % 100000;
                ndig = 5;
            end
            CMD_DEC4: begin
                v = num[15:0] % 10000;
                ndig = 4;
            end
            CMD_DEC3: begin
                v = num[7:0] % 1000;
                ndig = 3;
            end
            CMD_BIN8: begin
                // bit 7 leaves first
                for (int b = 7; b >= 0; b--)
                    digs.push_back({3'b000, num[b]});
            end
            default: begin
                // unused codes are taken and answered with nothing
            end
        endcase
        // fixed width modes keep their leading zeros
        repeat (ndig) begin
            digs.push_front(4'(v % 10));
            v = v / 10;
        end
        foreach (digs[i]) begin
            d.character = ASCII_ZERO + CHAR_W'(digs[i]);
            d.last      = (i == digs.size() - 1);
            digits_due.push_back(d);
        end
    endfunction

    // queues an answer typed into the directed table
    function automatic void queue_typed_digits(input string txt);
        byte    c;
        t_digit d;
        for (int i = 0; i < txt.len(); i++) begin
            c           = txt[i];
            d.character = c[CHAR_W-1:0];
            d.last      = (i == txt.len() - 1);
            digits_due.push_back(d);
        end
    endfunction

    // ------------------------------------------------------------------------
    // sender: offers one number, in bursts with random gaps between them,
    // and returns at the edge that takes it
    // ------------------------------------------------------------------------
    task automatic send_number(input logic [CMD_W-1:0] cmd,
                               input logic [NUM_W-1:0] num,
                               input string txt);
        int gap;
        if (burst_left == 0) begin
            // a quarter of the bursts follow the last one with no gap at all
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                @(negedge clk);
                in_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        in_ch.valid   = 1'b1;
        in_ch.command = cmd;
        in_ch.number  = num;
        row_txt       = txt;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // ------------------------------------------------------------------------
    // main stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        logic [CMD_W-1:0] cmd;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] pow;
        int               sent;
        in_ch.valid   = 1'b0;
        in_ch.command = CMD_DEC_VAR;
        in_ch.number  = '0;
        row_txt       = "";
        rst_n         = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tbl[i])
            send_number(dir_tbl[i].cmd, dir_tbl[i].num, dir_tbl[i].txt);

        // random part: every number counts toward the total
        sent = 0;
        while (sent < RANDOM_NUMBERS) begin
            if ($urandom_range(0, 15) < 2)
                cmd = CMD_W'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
            else
                cmd = CMD_W'($urandom_range(CMD_DEC_VAR, CMD_BIN8));
            case ($urandom_range(0, 5))
                0: num = {$urandom, $urandom};
                1: num = NUM_W'($urandom_range(0, 20));
                2: begin
                    // next to a power of ten, where the digit count changes
                    pow = 1;
                    repeat ($urandom_range(0, 19)) pow = pow * 10;
                    num = pow + $urandom_range(0, 2) - 1;
                end
                3: num = {$urandom, $urandom} >> $urandom_range(0, 63);
                4: num = ALL_ONES - $urandom_range(0, 3);
                default: num = {32'h0, $urandom};
            endcase
            send_number(cmd, num, "");
            sent++;
        end
        @(negedge clk);
        in_ch.valid = 1'b0;

        // the watchdog covers a burst that never comes
        while (digits_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("binary_to_decimal_ascii verification clean");
        else
            $display("binary_to_decimal_ascii verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: stalls in phases of its own (always ready, coin flips, or a
    // rotating bit pattern), plus one long hold that lets the block fill up
    // and push back on the sender
    // ------------------------------------------------------------------------
    initial begin
        t_rx_mode   rx_mode;
        logic [7:0] stall_pat;
        int         phase_left;
        bit         held;
        out_ch.ready = 1'b0;
        rx_mode      = RX_ALWAYS;
        stall_pat    = 8'hFF;
        phase_left   = 0;
        held         = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && numbers_taken >= HOLD_AT) begin
                held         = 1'b1;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (phase_left == 0) begin
                rx_mode    = t_rx_mode'($urandom_range(RX_ALWAYS, RX_PATTERN));
                stall_pat  = 8'($urandom) | 8'h01;
                phase_left = $urandom_range(16, 96);
            end
            phase_left--;
            case (rx_mode)
                RX_ALWAYS: out_ch.ready = 1'b1;
                RX_RANDOM: out_ch.ready = ($urandom_range(0, 1) == 1);
                default: begin
                    out_ch.ready = stall_pat[0];
                    stall_pat    = {stall_pat[0], stall_pat[7:1]};
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // monitor: a character transaction is checked against the oldest owed
    // character first, then a number transaction queues its burst, so both
    // in one edge give the same answer either way
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_digit want;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (digits_due.size() == 0) begin
                    $error("character: expected none, actual %0d (last %0b)",
                           out_ch.character, out_ch.last);
                    err_count++;
                end else begin
                    want = digits_due.pop_front();
                    if (out_ch.character !== want.character) begin
                        $error("character: expected %0d, actual %0d",
                               want.character, out_ch.character);
                        err_count++;
                    end
                    if (out_ch.last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, out_ch.last);
                        err_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                numbers_taken++;
                if (row_txt.len() != 0)
                    queue_typed_digits(row_txt);
                else
                    predict_digits(in_ch.command, in_ch.number);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any transaction means the block is stuck
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        int quiet_cycles;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("binary_to_decimal_ascii verification failed");
            $finish;
        end
    end

endmodule

FILE: sim.f
+incdir+sv
sv/b2da_pkg.sv
sv/b2da_ifs.sv
sv/b2da_front.sv
sv/b2da_queue.sv
sv/b2da_back.sv
sv/binary_to_decimal_ascii.sv
sv/b2da_checker.sv
test/tb_top.sv
